// ----- hw/rtl/stl_pkg.sv -----
// Shared types, token codes and character helper functions for the source text lexer.
`timescale 1ns / 1ps
package stl_pkg;

  // Token kinds
  localparam logic [5:0] K_RETURN   = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd3;
  localparam logic [5:0] K_BOOLLIT  = 6'd8;
  localparam logic [5:0] K_INTLIT   = 6'd9;
  localparam logic [5:0] K_CHARLIT  = 6'd10;
  localparam logic [5:0] K_STRLIT   = 6'd11;
  localparam logic [5:0] K_ASSIGN   = 6'd16;
  localparam logic [5:0] K_COLON    = 6'd17;
  localparam logic [5:0] K_COMMA    = 6'd18;
  localparam logic [5:0] K_LPAREN   = 6'd19;
  localparam logic [5:0] K_RPAREN   = 6'd20;
  localparam logic [5:0] K_LBRACE   = 6'd21;
  localparam logic [5:0] K_RBRACE   = 6'd22;
  localparam logic [5:0] K_PLUS     = 6'd23;
  localparam logic [5:0] K_MINUS    = 6'd24;
  localparam logic [5:0] K_STAR     = 6'd25;
  localparam logic [5:0] K_SLASH    = 6'd26;
  localparam logic [5:0] K_INC      = 6'd27;
  localparam logic [5:0] K_DEC      = 6'd28;
  localparam logic [5:0] K_EQ       = 6'd29;
  localparam logic [5:0] K_NE       = 6'd30;
  localparam logic [5:0] K_GE       = 6'd31;
  localparam logic [5:0] K_GT       = 6'd32;
  localparam logic [5:0] K_LE       = 6'd33;
  localparam logic [5:0] K_LT       = 6'd34;
  localparam logic [5:0] K_AND      = 6'd35;
  localparam logic [5:0] K_OR       = 6'd36;
  localparam logic [5:0] K_NOT      = 6'd37;
  localparam logic [5:0] K_ERROR    = 6'd38;

  // Error codes
  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_LONE_AMP  = 3'd1;
  localparam logic [2:0] E_LONE_BAR  = 3'd2;
  localparam logic [2:0] E_NO_QUOTE  = 3'd3;
  localparam logic [2:0] E_BAD_CHAR  = 3'd4;
  localparam logic [2:0] E_OPEN_STR  = 3'd5;
  localparam logic [2:0] E_INVALID   = 3'd6;
  localparam logic [2:0] E_TOO_LONG  = 3'd7;

  // Keyword table
  localparam int KW_NUM = 13;
  localparam int KW_MAXLEN = 6;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] line;
    logic [7:0]  value_char;
    logic        value_last;
    logic [2:0]  error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_HELD,
    SRC_MEM
  } src_e;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       set_held;
    logic       start_tok;
    logic       append;
    logic       clr_len;
    logic       line_inc;
    logic       eot_reset;
    logic       rd_start;
    logic       rd_issue;
    logic       rd_next;
    logic       emit;
    logic [5:0] emit_kind;
    src_e       emit_src;
    logic [2:0] emit_err;
    logic       emit_last_rd;
  } stl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [7:0] chr;
    logic       eot;
    logic [7:0] held;
    logic       len_zero;
    logic       len_full;
    logic       kw_hit;
    logic [5:0] kw_kind;
    logic       rd_last;
    logic       out_free;
  } stl_sts_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return (c == "=") || (c == "+") || (c == "-") || (c == "!") || (c == ">") ||
           (c == "<") || (c == "&") || (c == "|") || (c == "/");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0b) || (c == 8'h0c) ||
           (c == 8'h0d);
  endfunction

  // Single-character punctuation; bit 6 flags a match
  function automatic logic [6:0] punct_kind(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    case (c)
      ":":     r = {1'b1, K_COLON};
      ",":     r = {1'b1, K_COMMA};
      "(":     r = {1'b1, K_LPAREN};
      ")":     r = {1'b1, K_RPAREN};
      "{":     r = {1'b1, K_LBRACE};
      "}":     r = {1'b1, K_RBRACE};
      "*":     r = {1'b1, K_STAR};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Held operator standing alone
  function automatic logic [5:0] single_op_kind(input logic [7:0] h);
    logic [5:0] r;
    case (h)
      "=":     r = K_ASSIGN;
      "+":     r = K_PLUS;
      "-":     r = K_MINUS;
      "!":     r = K_NOT;
      ">":     r = K_GT;
      "<":     r = K_LT;
      "/":     r = K_SLASH;
      default: r = K_ERROR;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] single_op_err(input logic [7:0] h);
    logic [2:0] r;
    case (h)
      "=", "+", "-", "!", ">", "<", "/": r = E_NONE;
      "&":     r = E_LONE_AMP;
      default: r = E_LONE_BAR;
    endcase
    return r;
  endfunction

  // Two-character operator; K_RETURN means no pair
  function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [5:0] r;
    r = K_RETURN;
    if (c == "=") begin
      if (h == "=") r = K_EQ;
      else if (h == "!") r = K_NE;
      else if (h == ">") r = K_GE;
      else if (h == "<") r = K_LE;
    end else if (c == h) begin
      if (h == "+") r = K_INC;
      else if (h == "-") r = K_DEC;
      else if (h == "&") r = K_AND;
      else if (h == "|") r = K_OR;
    end
    return r;
  endfunction

  function automatic logic [47:0] kw_text(input int i);
    logic [47:0] t;
    case (i)
      0:       t = {"bool", 16'h0};
      1:       t = {"int", 24'h0};
      2:       t = {"char", 16'h0};
      3:       t = "string";
      4:       t = {"true", 16'h0};
      5:       t = {"false", 8'h0};
      6:       t = {"var", 24'h0};
      7:       t = {"func", 16'h0};
      8:       t = "return";
      9:       t = {"while", 8'h0};
      10:      t = {"if", 32'h0};
      11:      t = {"elif", 16'h0};
      default: t = {"else", 16'h0};
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_chr(input int i, input int p);
    logic [47:0] t;
    t = kw_text(i);
    return t[47 - 8 * p -: 8];
  endfunction

  function automatic logic [2:0] kw_len(input int i);
    logic [2:0] r;
    case (i)
      1, 6:       r = 3'd3;
      3, 8:       r = 3'd6;
      5, 9:       r = 3'd5;
      10:         r = 3'd2;
      default:    r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] kw_kind(input int i);
    logic [5:0] r;
    case (i)
      0:       r = 6'd4;
      1:       r = 6'd5;
      2:       r = 6'd6;
      3:       r = 6'd7;
      4, 5:    r = K_BOOLLIT;
      6:       r = 6'd1;
      7:       r = 6'd2;
      8:       r = K_RETURN;
      9:       r = 6'd12;
      10:      r = 6'd13;
      11:      r = 6'd14;
      default: r = 6'd15;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/stl_dp.sv -----
// Lexer datapath: input byte, held byte, token buffer, line counter, keyword match, output register.
`timescale 1ns / 1ps
module stl_dp import stl_pkg::*; #(
  parameter int TOKEN_MAX = 32,
  parameter int LINE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      out_stall_i,
  input  stl_cmd_t  cmd_i,
  output stl_sts_t  sts_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  localparam int LEN_W = $clog2(TOKEN_MAX + 1);
  localparam int IDX_W = $clog2(TOKEN_MAX);

  logic [7:0]           chr_q, held_q;
  logic                 eot_q;
  logic [LEN_W-1:0]     len_q, idx_q;
  logic [LINE_BITS-1:0] line_q;
  logic [KW_NUM-1:0]    kw_q, kw_d;
  logic [7:0]           mem [TOKEN_MAX];
  logic [7:0]           rdata_q;
  logic                 out_valid_q;
  out_item_t            out_q;
  logic [15:0]          line_out;
  logic                 kw_hit;
  logic [5:0]           kw_k;
  logic [7:0]           vchar;

  // Saturated line number for the result field
  if (LINE_BITS > 16) begin : g_line_wide
    assign line_out = (line_q > LINE_BITS'(16'hffff)) ? 16'hffff : line_q[15:0];
  end else begin : g_line_narrow
    assign line_out = 16'(line_q);
  end

  // Running keyword match, one compare per keyword per appended byte
  always_comb begin
    kw_d = kw_q;
    for (int i = 0; i < KW_NUM; i++) begin
      if (cmd_i.start_tok) begin
        kw_d[i] = (kw_chr(i, 0) == chr_q);
      end else if (cmd_i.append) begin
        if ((len_q < LEN_W'(KW_MAXLEN)) && (len_q < LEN_W'(kw_len(i))))
          kw_d[i] = kw_q[i] && (kw_chr(i, int'(len_q)) == chr_q);
        else
          kw_d[i] = 1'b0;
      end
    end
  end

  always_comb begin
    kw_hit = 1'b0;
    kw_k   = K_IDENT;
    for (int i = 0; i < KW_NUM; i++) begin
      if (kw_q[i] && (len_q == LEN_W'(kw_len(i)))) begin
        kw_hit = 1'b1;
        kw_k   = kw_kind(i);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 8'd0;
      len_q       <= '0;
      idx_q       <= '0;
      line_q      <= LINE_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_held) held_q <= chr_q;
      if (cmd_i.start_tok) len_q <= LEN_W'(1);
      else if (cmd_i.append) len_q <= len_q + LEN_W'(1);
      else if (cmd_i.clr_len) len_q <= '0;
      if (cmd_i.rd_start) idx_q <= '0;
      else if (cmd_i.rd_next) idx_q <= idx_q + LEN_W'(1);
      if (cmd_i.line_inc && (line_q != '1)) line_q <= line_q + LINE_BITS'(1);
      if (cmd_i.eot_reset) begin
        held_q <= 8'd0;
        len_q  <= '0;
        line_q <= LINE_BITS'(1);
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.emit_src)
      SRC_HELD: vchar = held_q;
      SRC_MEM:  vchar = rdata_q;
      default:  vchar = 8'd0;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      chr_q <= in_item_i.char_in;
      eot_q <= in_item_i.end_of_text;
    end
    if (cmd_i.start_tok || cmd_i.append) kw_q <= kw_d;
    if (cmd_i.emit) begin
      out_q.token_kind <= cmd_i.emit_kind;
      out_q.line       <= line_out;
      out_q.value_char <= vchar;
      out_q.value_last <= cmd_i.emit_last_rd ? sts_o.rd_last : 1'b1;
      out_q.error_code <= cmd_i.emit_err;
    end
  end

  // Token buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_tok) mem[0] <= chr_q;
    else if (cmd_i.append) mem[len_q[IDX_W-1:0]] <= chr_q;
    if (cmd_i.rd_issue) rdata_q <= mem[idx_q[IDX_W-1:0]];
  end

  assign sts_o.chr      = chr_q;
  assign sts_o.eot      = eot_q;
  assign sts_o.held     = held_q;
  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.len_full = (len_q == LEN_W'(TOKEN_MAX));
  assign sts_o.kw_hit   = kw_hit;
  assign sts_o.kw_kind  = kw_k;
  assign sts_o.rd_last  = ((idx_q + LEN_W'(1)) == len_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/stl_ctrl.sv -----
// Lexer controller: lexing mode and the per-item step sequencer.
`timescale 1ns / 1ps
module stl_ctrl import stl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  stl_sts_t sts_i,
  output stl_cmd_t cmd_o,
  output logic     halted_o
);

  typedef enum logic [3:0] {
    MD_IDLE, MD_IDENT, MD_NUMBER, MD_OP, MD_LINECMT, MD_BLOCK, MD_BLOCKSTAR,
    MD_CHAROPEN, MD_CHARCLOSE, MD_STRING
  } mode_e;

  typedef enum logic [3:0] {
    ST_ACC, ST_DO, ST_IC, ST_ONE, ST_FL, ST_RD, ST_EM, ST_POST, ST_HALT
  } state_e;

  typedef enum logic [1:0] {
    P_NONE, P_IDLEC, P_EOT
  } post_e;

  state_e     st_q, st_d;
  mode_e      md_q, md_d;
  post_e      post_q, post_d;
  logic [5:0] one_kind_q, one_kind_d, fl_kind_q, fl_kind_d;
  logic [2:0] one_err_q, one_err_d;
  src_e       one_src_q, one_src_d;
  logic [6:0] pk;
  logic [5:0] pair;
  logic [7:0] c;

  assign c    = sts_i.chr;
  assign pk   = punct_kind(c);
  assign pair = pair_kind(sts_i.held, c);

  assign in_stall_o = !((st_q == ST_ACC) || (st_q == ST_HALT));
  assign halted_o   = (st_q == ST_HALT);

  always_comb begin
    st_d       = st_q;
    md_d       = md_q;
    post_d     = post_q;
    one_kind_d = one_kind_q;
    one_err_d  = one_err_q;
    one_src_d  = one_src_q;
    fl_kind_d  = fl_kind_q;
    cmd_o      = '0;
    cmd_o.emit_src = SRC_ZERO;

    case (st_q)
      // Wait for the next item
      ST_ACC: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          st_d = ST_DO;
        end
      end

      // Classify the latched byte against the current mode
      ST_DO: begin
        st_d = ST_ACC;
        one_err_d = E_NONE;
        one_src_d = SRC_ZERO;
        post_d = P_NONE;
        if (sts_i.eot) begin
          case (md_q)
            MD_IDENT, MD_NUMBER: begin
              fl_kind_d = (md_q == MD_IDENT) ? K_IDENT : K_INTLIT;
              post_d = P_EOT;
              st_d = ST_FL;
            end
            MD_OP: begin
              one_kind_d = single_op_kind(sts_i.held);
              one_err_d  = single_op_err(sts_i.held);
              post_d = P_EOT;
              st_d = ST_ONE;
            end
            MD_CHAROPEN, MD_CHARCLOSE, MD_STRING: begin
              one_kind_d = K_ERROR;
              one_err_d  = (md_q == MD_CHAROPEN) ? E_BAD_CHAR :
                           (md_q == MD_CHARCLOSE) ? E_NO_QUOTE : E_OPEN_STR;
              st_d = ST_ONE;
            end
            default: begin
              cmd_o.eot_reset = 1'b1;
            end
          endcase
          md_d = MD_IDLE;
        end else begin
          case (md_q)
            MD_IDENT, MD_NUMBER: begin
              if ((md_q == MD_IDENT) ? (is_alpha(c) || is_digit(c) || (c == "_"))
                                     : is_digit(c)) begin
                if (sts_i.len_full) begin
                  one_kind_d = K_ERROR;
                  one_err_d  = E_TOO_LONG;
                  st_d = ST_ONE;
                end else begin
                  cmd_o.append = 1'b1;
                end
              end else begin
                fl_kind_d = (md_q == MD_IDENT) ? K_IDENT : K_INTLIT;
                post_d = P_IDLEC;
                md_d = MD_IDLE;
                st_d = ST_FL;
              end
            end
            MD_OP: begin
              md_d = MD_IDLE;
              if ((sts_i.held == "/") && (c == "/")) begin
                md_d = MD_LINECMT;
              end else if ((sts_i.held == "/") && (c == "*")) begin
                md_d = MD_BLOCK;
              end else if (pair != K_RETURN) begin
                one_kind_d = pair;
                st_d = ST_ONE;
              end else begin
                one_kind_d = single_op_kind(sts_i.held);
                one_err_d  = single_op_err(sts_i.held);
                post_d = P_IDLEC;
                st_d = ST_ONE;
              end
            end
            MD_LINECMT: begin
              if (c == 8'h0a) begin
                cmd_o.line_inc = 1'b1;
                md_d = MD_IDLE;
              end
            end
            MD_BLOCK: begin
              if (c == "*") md_d = MD_BLOCKSTAR;
              else if (c == 8'h0a) cmd_o.line_inc = 1'b1;
            end
            MD_BLOCKSTAR: begin
              if (c == "/") md_d = MD_IDLE;
              else if (c != "*") begin
                cmd_o.line_inc = (c == 8'h0a);
                md_d = MD_BLOCK;
              end
            end
            MD_CHAROPEN: begin
              if (is_alpha(c) || is_digit(c)) begin
                cmd_o.set_held = 1'b1;
                md_d = MD_CHARCLOSE;
              end else begin
                one_kind_d = K_ERROR;
                one_err_d  = E_BAD_CHAR;
                st_d = ST_ONE;
              end
            end
            MD_CHARCLOSE: begin
              md_d = MD_IDLE;
              if (c == 8'h27) begin
                one_kind_d = K_CHARLIT;
                one_src_d  = SRC_HELD;
              end else begin
                one_kind_d = K_ERROR;
                one_err_d  = E_NO_QUOTE;
              end
              st_d = ST_ONE;
            end
            MD_STRING: begin
              if (c == 8'h22) begin
                fl_kind_d = K_STRLIT;
                md_d = MD_IDLE;
                st_d = ST_FL;
              end else begin
                cmd_o.line_inc = (c == 8'h0a);
                if (sts_i.len_full) begin
                  one_kind_d = K_ERROR;
                  one_err_d  = E_TOO_LONG;
                  st_d = ST_ONE;
                end else begin
                  cmd_o.append = 1'b1;
                end
              end
            end
            default: begin
              st_d = ST_IC;
            end
          endcase
        end
      end

      // Start of a token from the idle mode
      ST_IC: begin
        st_d = ST_ACC;
        md_d = MD_IDLE;
        post_d = P_NONE;
        one_err_d = E_NONE;
        one_src_d = SRC_ZERO;
        if (is_alpha(c) || is_digit(c)) begin
          cmd_o.start_tok = 1'b1;
          md_d = is_alpha(c) ? MD_IDENT : MD_NUMBER;
        end else begin
          cmd_o.clr_len = 1'b1;
          if (is_op_start(c)) begin
            cmd_o.set_held = 1'b1;
            md_d = MD_OP;
          end else if (pk[6]) begin
            one_kind_d = pk[5:0];
            st_d = ST_ONE;
          end else if (c == 8'h27) begin
            md_d = MD_CHAROPEN;
          end else if (c == 8'h22) begin
            md_d = MD_STRING;
          end else if (c == 8'h0a) begin
            cmd_o.line_inc = 1'b1;
          end else if (!is_space(c)) begin
            one_kind_d = K_ERROR;
            one_err_d  = E_INVALID;
            st_d = ST_ONE;
          end
        end
      end

      // One result of its own; an error halts
      ST_ONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = (one_err_q != E_NONE) ? K_ERROR : one_kind_q;
          cmd_o.emit_src  = one_src_q;
          cmd_o.emit_err  = one_err_q;
          st_d = (one_err_q != E_NONE) ? ST_HALT : ST_POST;
        end
      end

      // Buffered token: keyword check, then replay
      ST_FL: begin
        one_err_d = E_NONE;
        one_src_d = SRC_ZERO;
        cmd_o.clr_len = 1'b0;
        if ((fl_kind_q == K_IDENT) && sts_i.kw_hit && (sts_i.kw_kind != K_BOOLLIT)) begin
          cmd_o.clr_len = 1'b1;
          one_kind_d = sts_i.kw_kind;
          st_d = ST_ONE;
        end else if (sts_i.len_zero) begin
          one_kind_d = fl_kind_q;
          st_d = ST_ONE;
        end else begin
          if ((fl_kind_q == K_IDENT) && sts_i.kw_hit) fl_kind_d = K_BOOLLIT;
          cmd_o.rd_start = 1'b1;
          st_d = ST_RD;
        end
      end

      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        st_d = ST_EM;
      end

      ST_EM: begin
        if (sts_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.emit_kind    = fl_kind_q;
          cmd_o.emit_src     = SRC_MEM;
          cmd_o.emit_last_rd = 1'b1;
          cmd_o.rd_next      = 1'b1;
          if (sts_i.rd_last) begin
            cmd_o.clr_len = 1'b1;
            st_d = ST_POST;
          end else begin
            st_d = ST_RD;
          end
        end
      end

      // What follows a finished result
      ST_POST: begin
        case (post_q)
          P_IDLEC: st_d = ST_IC;
          P_EOT: begin
            cmd_o.eot_reset = 1'b1;
            md_d = MD_IDLE;
            st_d = ST_ACC;
          end
          default: st_d = ST_ACC;
        endcase
      end

      // Items are taken and dropped until reset
      ST_HALT: begin
        st_d = ST_HALT;
      end

      default: st_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_ACC;
      md_q       <= MD_IDLE;
      post_q     <= P_NONE;
      one_kind_q <= K_RETURN;
      one_err_q  <= E_NONE;
      one_src_q  <= SRC_ZERO;
      fl_kind_q  <= K_IDENT;
    end else begin
      st_q       <= st_d;
      md_q       <= md_d;
      post_q     <= post_d;
      one_kind_q <= one_kind_d;
      one_err_q  <= one_err_d;
      one_src_q  <= one_src_d;
      fl_kind_q  <= fl_kind_d;
    end
  end

endmodule

// ----- hw/rtl/source_text_lexer.sv -----
// Top level of the source text lexer: controller, datapath and checks.
//
//   channel | direction | handshake               | item
//   in      | input     | in_valid_i / in_stall_o   | in_item_t  (char_in, end_of_text)
//   out     | output    | out_valid_o / out_stall_i | out_item_t (kind, line, value, last, error)
//
// A byte is accepted (ST_ACC), then classified (ST_DO); one met in the idle mode also passes
// ST_IC, which starts its token. A single result adds an emit (ST_ONE) and a finish (ST_POST).
// A buffered token adds a keyword check (ST_FL), a buffer read and an output register load per
// character (ST_RD, ST_EM) and a finish; the single-port token buffer read sets the read step.
// Reset clears mode, held byte, length and sets the line to 1; no clearing pass.
// A stalled output holds the sequencer until the output register frees.
`timescale 1ns / 1ps
module source_text_lexer import stl_pkg::*; #(
  parameter int TOKEN_MAX = 32,
  parameter int LINE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  stl_cmd_t cmd;
  stl_sts_t sts;
  logic     halted;

  stl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .halted_o   (halted)
  );

  stl_dp #(
    .TOKEN_MAX (TOKEN_MAX),
    .LINE_BITS (LINE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // An error code only travels with the error kind
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.error_code != E_NONE)) |-> (out_item_o.token_kind == K_ERROR))
    else $error("error code on a non-error item");

  // Line count never drops to zero
  a_line_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.line != 16'd0))
    else $error("line zero on output");

  // Nothing follows a delivered error
  a_err_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && (out_item_o.error_code != E_NONE)) |=> !out_valid_o)
    else $error("result after error");

  // No new result is loaded once halted
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted |-> !cmd.emit)
    else $error("emit while halted");

endmodule

// ----- verif/source_text_lexer_test.sv -----
// Self-checking testbench for the source text lexer, with its own token predictor.
`timescale 1ns / 1ps
module source_text_lexer_test;
  import stl_pkg::*;

  localparam int TOK_MAX = 32;
  localparam int LINE_TOP = 65535;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 370;
  localparam int RAND_END = ITEM_TARGET - 30;

  // Keyword kinds the package leaves unnamed
  localparam logic [5:0] K_VAR     = 6'd1;
  localparam logic [5:0] K_FUNC    = 6'd2;
  localparam logic [5:0] K_BOOL    = 6'd4;
  localparam logic [5:0] K_INT     = 6'd5;
  localparam logic [5:0] K_CHAR    = 6'd6;
  localparam logic [5:0] K_STRING  = 6'd7;
  localparam logic [5:0] K_WHILE   = 6'd12;
  localparam logic [5:0] K_IF      = 6'd13;
  localparam logic [5:0] K_ELIF    = 6'd14;
  localparam logic [5:0] K_ELSE    = 6'd15;

  typedef enum int {
    LX_IDLE, LX_WORD, LX_NUM, LX_OP, LX_LINE_CMT, LX_BLK_CMT, LX_BLK_STAR,
    LX_CHR_OPEN, LX_CHR_CLOSE, LX_STR
  } lex_mode_e;

  // Token predictor and store of expected token results
  class token_scoreboard;
    out_item_t expected_tokens[$];
    int        mismatches;
    lex_mode_e mode;
    logic [7:0] held;
    logic [7:0] text_buf[TOK_MAX];
    int        text_len;
    int        line_no;
    bit        stopped;
    string     kw_txt[13];
    logic [5:0] kw_kd[13];

    function new();
      kw_txt = '{"bool", "int", "char", "string", "true", "false", "var", "func",
                 "return", "while", "if", "elif", "else"};
      kw_kd = '{K_BOOL, K_INT, K_CHAR, K_STRING, K_BOOLLIT, K_BOOLLIT, K_VAR, K_FUNC,
                K_RETURN, K_WHILE, K_IF, K_ELIF, K_ELSE};
      mode = LX_IDLE;
      held = '0;
      text_len = 0;
      line_no = 1;
      stopped = 0;
      mismatches = 0;
    endfunction

    function void emit(logic [5:0] k, logic [7:0] v, logic l, logic [2:0] e);
      out_item_t r;
      r.token_kind = k;
      r.line = line_no[15:0];
      r.value_char = v;
      r.value_last = l;
      r.error_code = e;
      expected_tokens = {expected_tokens, r};
    endfunction

    function void halt_on(logic [2:0] code);
      emit(K_ERROR, 8'd0, 1'b1, code);
      stopped = 1;
      mode = LX_IDLE;
    endfunction

    function void next_line();
      if (line_no < LINE_TOP) line_no++;
    endfunction

    function void emit_text(logic [5:0] k);
      if (text_len == 0) emit(k, 8'd0, 1'b1, E_NONE);
      else for (int i = 0; i < text_len; i++) emit(k, text_buf[i], i + 1 == text_len, E_NONE);
    endfunction

    function void add_char(logic [7:0] c);
      if (text_len >= TOK_MAX) halt_on(E_TOO_LONG);
      else text_buf[text_len++] = c;
    endfunction

    function void flush_word();
      bit hit;
      for (int i = 0; i < 13; i++) begin
        hit = (kw_txt[i].len() == text_len);
        for (int j = 0; hit && j < text_len; j++) hit = (kw_txt[i][j] == text_buf[j]);
        if (hit) begin
          if (kw_kd[i] == K_BOOLLIT) emit_text(K_BOOLLIT);
          else emit(kw_kd[i], 8'd0, 1'b1, E_NONE);
          text_len = 0;
          return;
        end
      end
      emit_text(K_IDENT);
      text_len = 0;
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    // Held operator on its own; error code nonzero for & and |
    function logic [5:0] lone_op(logic [7:0] h, output logic [2:0] e);
      e = E_NONE;
      case (h)
        "=": return K_ASSIGN;
        "+": return K_PLUS;
        "-": return K_MINUS;
        "!": return K_NOT;
        ">": return K_GT;
        "<": return K_LT;
        "/": return K_SLASH;
        "&": e = E_LONE_AMP;
        default: e = E_LONE_BAR;
      endcase
      return K_ERROR;
    endfunction

    function void start_token(logic [7:0] c);
      text_len = 0;
      mode = LX_IDLE;
      if (letter(c)) begin
        text_buf[0] = c; text_len = 1; mode = LX_WORD;
      end else if (digit(c)) begin
        text_buf[0] = c; text_len = 1; mode = LX_NUM;
      end else begin
        case (c)
          "=", "+", "-", "!", ">", "<", "&", "|", "/": begin
            held = c; mode = LX_OP;
          end
          ":": emit(K_COLON, 8'd0, 1'b1, E_NONE);
          ",": emit(K_COMMA, 8'd0, 1'b1, E_NONE);
          "(": emit(K_LPAREN, 8'd0, 1'b1, E_NONE);
          ")": emit(K_RPAREN, 8'd0, 1'b1, E_NONE);
          "{": emit(K_LBRACE, 8'd0, 1'b1, E_NONE);
          "}": emit(K_RBRACE, 8'd0, 1'b1, E_NONE);
          "*": emit(K_STAR, 8'd0, 1'b1, E_NONE);
          "'": mode = LX_CHR_OPEN;
          "\"": mode = LX_STR;
          8'h0a: next_line();
          8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d: ;
          default: halt_on(E_INVALID);
        endcase
      end
    endfunction

    function void op_follow(logic [7:0] c);
      logic [5:0] k;
      logic [2:0] e;
      mode = LX_IDLE;
      k = K_RETURN;
      if (held == "/" && c == "/") begin mode = LX_LINE_CMT; return; end
      if (held == "/" && c == "*") begin mode = LX_BLK_CMT; return; end
      if (c == "=") begin
        if (held == "=") k = K_EQ;
        else if (held == "!") k = K_NE;
        else if (held == ">") k = K_GE;
        else if (held == "<") k = K_LE;
      end else if (c == held) begin
        if (held == "+") k = K_INC;
        else if (held == "-") k = K_DEC;
        else if (held == "&") k = K_AND;
        else if (held == "|") k = K_OR;
      end
      if (k != K_RETURN) begin emit(k, 8'd0, 1'b1, E_NONE); return; end
      k = lone_op(held, e);
      if (e != E_NONE) begin halt_on(e); return; end
      emit(k, 8'd0, 1'b1, E_NONE);
      start_token(c);
    endfunction

    // Works out the results that one accepted input item causes
    function void note_input(in_item_t it);
      logic [7:0] c;
      logic [5:0] k;
      logic [2:0] e;
      c = it.char_in;
      if (stopped) return;
      if (it.end_of_text) begin
        case (mode)
          LX_WORD: flush_word();
          LX_NUM: emit_text(K_INTLIT);
          LX_OP: begin
            k = lone_op(held, e);
            if (e != E_NONE) halt_on(e); else emit(k, 8'd0, 1'b1, E_NONE);
          end
          LX_CHR_OPEN: halt_on(E_BAD_CHAR);
          LX_CHR_CLOSE: halt_on(E_NO_QUOTE);
          LX_STR: halt_on(E_OPEN_STR);
          default: ;
        endcase
        if (!stopped) begin
          mode = LX_IDLE; held = '0; text_len = 0; line_no = 1;
        end
        return;
      end
      case (mode)
        LX_WORD:
          if (letter(c) || digit(c) || c == "_") add_char(c);
          else begin flush_word(); start_token(c); end
        LX_NUM:
          if (digit(c)) add_char(c);
          else begin emit_text(K_INTLIT); text_len = 0; start_token(c); end
        LX_OP: op_follow(c);
        LX_LINE_CMT:
          if (c == 8'h0a) begin next_line(); mode = LX_IDLE; end
        LX_BLK_CMT:
          if (c == "*") mode = LX_BLK_STAR;
          else if (c == 8'h0a) next_line();
        LX_BLK_STAR:
          if (c == "/") mode = LX_IDLE;
          else if (c != "*") begin
            if (c == 8'h0a) next_line();
            mode = LX_BLK_CMT;
          end
        LX_CHR_OPEN:
          if (letter(c) || digit(c)) begin held = c; mode = LX_CHR_CLOSE; end
          else halt_on(E_BAD_CHAR);
        LX_CHR_CLOSE:
          if (c == "'") begin emit(K_CHARLIT, held, 1'b1, E_NONE); mode = LX_IDLE; end
          else halt_on(E_NO_QUOTE);
        LX_STR:
          if (c == "\"") begin
            emit_text(K_STRLIT); text_len = 0; mode = LX_IDLE;
          end else begin
            if (c == 8'h0a) next_line();
            add_char(c);
          end
        default: start_token(c);
      endcase
    endfunction

    // Compares one accepted token result with the oldest expectation
    function void check_token(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token result, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind != want.token_kind || got.line != want.line ||
          got.value_char != want.value_char || got.value_last != want.value_last ||
          got.error_code != want.error_code) begin
        $display("%0t: token mismatch, expected kind %0d line %0d char %h last %b err %0d,",
                 $time, want.token_kind, want.line, want.value_char, want.value_last,
                 want.error_code);
        $display("  got kind %0d line %0d char %h last %b err %0d",
                 got.token_kind, got.line, got.value_char, got.value_last, got.error_code);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  bit        busy_phase;
  longint    cycles = 0;

  token_scoreboard sb;
  in_item_t  src_bytes[$];
  int        queued_items = 0;

  source_text_lexer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!busy_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= busy_phase && ($urandom_range(0, 99) < 30 ||
                                     ($urandom_range(0, 99) < 3 && !out_stall));
  end

  // Monitors on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_token(out_item);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** source_text_lexer: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [7:0] c, logic eot);
    in_item_t it;
    it.char_in = c;
    it.end_of_text = eot;
    return it;
  endfunction

  // Appends one item to the send queue
  function automatic void queue_byte(in_item_t it);
    src_bytes = {src_bytes, it};
    queued_items++;
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(mk(s[i], 1'b0));
  endtask

  task automatic put_eot();
    queue_byte(mk(8'($urandom), 1'b1));
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "a" + c : "A" + c;
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_letter();
    if (r < 9) return "0" + 8'($urandom_range(0, 9));
    return "_";
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return TOK_MAX;
    if (r < 3) return $urandom_range(9, TOK_MAX);
    return $urandom_range(1, 8);
  endfunction

  // One well-formed token with random content, then a separator
  task automatic put_rand_token();
    string ops[19] = '{"=", "+", "-", "!", ">", "<", "/", "++", "--", "==", "!=", ">=",
                      "<=", "&&", "||", ":", ",", "(", ")"};
    string kws[13] = '{"bool", "int", "char", "string", "true", "false", "var", "func",
                       "return", "while", "if", "elif", "else"};
    string seps = " \t\n\r\v\f";
    logic [7:0] c;
    int n;
    case ($urandom_range(0, 10))
      0, 1: begin
        n = rand_len();
        queue_byte(mk(rand_letter(), 1'b0));
        for (int i = 1; i < n; i++) queue_byte(mk(rand_word_char(), 1'b0));
      end
      2: put_text(kws[$urandom_range(0, 12)]);
      3: begin
        n = rand_len();
        for (int i = 0; i < n; i++) queue_byte(mk("0" + 8'($urandom_range(0, 9)), 1'b0));
      end
      4: begin
        put_text("'");
        queue_byte(mk($urandom_range(0, 1) ? rand_letter() :
                      "0" + 8'($urandom_range(0, 9)), 1'b0));
        put_text("'");
      end
      5: begin
        n = $urandom_range(0, 3) == 0 ? rand_len() - 1 : $urandom_range(0, 6);
        put_text("\"");
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom); while (c == "\"");
          queue_byte(mk(c, 1'b0));
        end
        put_text("\"");
      end
      6: put_text(ops[$urandom_range(0, 18)]);
      7: put_text($urandom_range(0, 1) ? "{}" : "*");
      8: begin
        put_text("//");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom); while (c == 8'h0a);
          queue_byte(mk(c, 1'b0));
        end
        put_text("\n");
      end
      9: begin
        put_text("/*");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom); while (c == "/");
          queue_byte(mk($urandom_range(0, 3) == 0 ? "*" : c, 1'b0));
        end
        put_text("*/");
      end
      default: put_text("\n");
    endcase
    queue_byte(mk(seps[$urandom_range(0, 5)], 1'b0));
    if ($urandom_range(0, 24) == 0) put_eot();
  endtask

  // Exactly one halting error; the block stays halted until reset
  task automatic put_error_case();
    case ($urandom_range(0, 8))
      0: begin put_text("&"); put_eot(); end
      1: put_text("&x");
      2: begin put_text("|"); put_eot(); end
      3: put_text("|=");
      4: put_text("'ab");
      5: put_text("'#");
      6: begin put_text("\"open\nstr"); put_eot(); end
      7: put_text($urandom_range(0, 1) ? "#" : "\x80");
      default: begin
        for (int i = 0; i <= TOK_MAX; i++) queue_byte(mk(rand_word_char() | 8'h40, 1'b0));
      end
    endcase
    put_text("after x = 1 ");
    put_eot();
  endtask

  // Sends every queued byte on the input channel
  task automatic send_all();
    in_item_t it;
    int g;
    while (src_bytes.size() != 0) begin
      it = src_bytes.pop_front();
      g = pick_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item <= it;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int  mid_mark;
    bit  mid_done;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    busy_phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: keywords, literals, operators, comments and flushes at end of text
    put_text("bool int char string true false var func return while if elif else\n");
    put_text("foo_1 Z9 0 12345 'a' '9' \"\" \"hi\nthere\" ");
    put_text("= : , ( ) { } + - * / ++ -- == != >= > <= < && || ! x+y a=b//c\n/* x ** \n*/");
    put_text("abcdefghijklmnopqrstuvwxyzABCDEF \"0123456789012345678901234567890\xff\" ");
    put_text("ident");
    put_eot();
    put_text("42");
    put_eot();
    put_text("/* never closed");
    put_eot();
    put_text("<");
    put_eot();
    send_all();
    drain();

    // Random well-formed source text; halfway the sender waits for every result
    busy_phase = 1;
    mid_mark = (queued_items + RAND_END) / 2;
    mid_done = 0;
    while (queued_items < RAND_END) begin
      put_rand_token();
      if (!mid_done && queued_items >= mid_mark) begin
        mid_done = 1;
        send_all();
        drain();
      end
    end
    put_eot();
    send_all();
    drain();

    put_error_case();
    send_all();
    drain();

    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("** source_text_lexer: PASSED **");
    end else begin
      $display("** source_text_lexer: FAILED **");
    end
    $finish;
  end

endmodule
